@@ rtl/rtnp_pkg.sv @@
`default_nettype none
package rtnp_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W = 33;
  localparam int MUL_W = 35;
  localparam int PROD_W = 70;
  localparam int NRM_W = 67;
  localparam int DEN_W = 66;
  localparam int NUM_W = 68;
  localparam int ACC_W = 104;
  localparam int SPLIT = 34;
  localparam int DIST_W = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;

  typedef logic [2:0][COORD_W-1:0] vec_t;
  typedef logic [2:0][DIFF_W-1:0] dvec_t;

  // ea = c - a, eb = b - c, ec = a - b: the edges in the winding a, c, b.
  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t c;
    dvec_t ea;
    dvec_t eb;
    dvec_t ec;
    logic last;
  } entry_t;

endpackage
`default_nettype wire

@@ rtl/rtnp_front.sv @@
`default_nettype none
module rtnp_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  input  wire logic [9*rtnp_pkg::COORD_W-1:0] in_tdata,
  input  wire logic in_tlast,
  output logic push_valid,
  input  wire logic push_ready,
  output rtnp_pkg::entry_t push_entry
);

  logic fr_valid_r;
  rtnp_pkg::entry_t fr_ent_r;
  rtnp_pkg::entry_t ent_nxt;

  assign in_tready = !fr_valid_r || push_ready;
  assign push_valid = fr_valid_r;
  assign push_entry = fr_ent_r;

  always_comb begin
    ent_nxt.last = in_tlast;
    for (int k = 0; k < 3; k++) begin
      ent_nxt.a[k] = in_tdata[k*32 +: 32];
      ent_nxt.b[k] = in_tdata[(3+k)*32 +: 32];
      ent_nxt.c[k] = in_tdata[(6+k)*32 +: 32];
      ent_nxt.ea[k] = 33'($signed(ent_nxt.c[k])) - 33'($signed(ent_nxt.a[k]));
      ent_nxt.eb[k] = 33'($signed(ent_nxt.b[k])) - 33'($signed(ent_nxt.c[k]));
      ent_nxt.ec[k] = 33'($signed(ent_nxt.a[k])) - 33'($signed(ent_nxt.b[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        fr_valid_r <= 1'b1;
        fr_ent_r <= ent_nxt;
      end else if (push_ready) begin
        fr_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/rtnp_fifo.sv @@
`default_nettype none
module rtnp_fifo #(
  parameter int DEPTH = rtnp_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic push_ready,
  input  wire rtnp_pkg::entry_t push_entry,
  output logic pop_valid,
  input  wire logic pop_ready,
  output rtnp_pkg::entry_t pop_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rtnp_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic do_push;
  logic do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/rtnp_div.sv @@
`default_nettype none
module rtnp_div (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic [rtnp_pkg::ACC_W-1:0] dividend,
  input  wire logic [rtnp_pkg::DEN_W-1:0] divisor,
  output logic done,
  output logic [rtnp_pkg::ACC_W-1:0] quotient
);

  localparam int N = rtnp_pkg::ACC_W;
  localparam int M = rtnp_pkg::DEN_W;
  localparam int CW = $clog2(N + 1);

  logic busy_r;
  logic done_r;
  logic neg_r;
  logic [CW-1:0] cnt_r;
  logic [M-1:0] rem_r;
  logic [M-1:0] dv_r;
  logic [N-1:0] q_r;
  logic [M:0] rs;
  logic ge;

  assign rs = {rem_r, q_r[N-1]};
  assign ge = (rs >= {1'b0, dv_r});
  assign done = done_r;
  assign quotient = neg_r ? (~q_r + 1'b1) : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        neg_r <= dividend[N-1] ^ divisor[M-1];
        q_r <= dividend[N-1] ? (~dividend + 1'b1) : dividend;
        dv_r <= divisor[M-1] ? (~divisor + 1'b1) : divisor;
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= M'(rs - {1'b0, dv_r});
          q_r <= {q_r[N-2:0], 1'b1};
        end else begin
          rem_r <= rs[M-1:0];
          q_r <= {q_r[N-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/rtnp_back.sv @@
`default_nettype none
module rtnp_back (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire rtnp_pkg::vec_t cfg_o,
  input  wire rtnp_pkg::vec_t cfg_d,
  input  wire logic pop_valid,
  output logic pop_ready,
  input  wire rtnp_pkg::entry_t pop_entry,
  output logic out_tvalid,
  input  wire logic out_tready,
  output logic [63:0] out_tdata,
  output logic out_tuser
);

  typedef enum logic [3:0] {
    S_IDLE, S_CROSS, S_NORM, S_DEN, S_NUM, S_PROD, S_DIV, S_DOT, S_DIST, S_FIN
  } state_t;

  localparam int AW = rtnp_pkg::ACC_W;
  localparam int MW = rtnp_pkg::MUL_W;
  localparam int SP = rtnp_pkg::SPLIT;

  state_t state_r;
  logic ph_r;
  logic [2:0] tc_r;
  logic [1:0] ci_r;
  logic [1:0] edge_r;
  logic nrm_ph_r;
  rtnp_pkg::entry_t ent_r;
  logic [2:0][rtnp_pkg::NRM_W-1:0] nrm_r;
  logic [2:0][rtnp_pkg::NRM_W-1:0] t_r;
  logic [2:0][rtnp_pkg::COORD_W-1:0] h_r;
  logic [rtnp_pkg::DEN_W-1:0] den_r;
  logic [rtnp_pkg::NUM_W-1:0] num_r;
  logic [AW-1:0] acc_r;
  logic signed [rtnp_pkg::PROD_W-1:0] prod_r;
  logic sh_r;
  logic neg_r;
  logic any_hit_r;
  logic [rtnp_pkg::DIST_W-1:0] best_d_r;
  logic [31:0] best_x_r;
  logic [31:0] best_y_r;
  logic out_valid_r;
  logic out_picked_r;
  logic [63:0] out_data_r;

  logic signed [MW-1:0] op_a;
  logic signed [MW-1:0] op_b;
  logic op_neg;
  logic op_sh;
  logic term_last;
  rtnp_pkg::dvec_t e_sel;
  rtnp_pkg::vec_t p_sel;
  rtnp_pkg::dvec_t f_v;
  rtnp_pkg::dvec_t u_v;
  rtnp_pkg::dvec_t v_v;
  logic [AW-1:0] term_ext;
  logic [AW-1:0] term_sh;
  logic [AW-1:0] base;
  logic [AW-1:0] acc_sum;
  logic [rtnp_pkg::NRM_W-1:0] mag_or;
  logic div_start;
  logic div_done;
  logic [AW-1:0] div_q;
  logic [AW-1:0] osum;
  logic [31:0] h_sat;
  logic [rtnp_pkg::DIST_W-1:0] dist_val;
  logic out_free;
  logic out_load;

  function automatic logic [1:0] nx3(input logic [1:0] i);
    nx3 = (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  function automatic logic [1:0] pv3(input logic [1:0] i);
    pv3 = (i == 2'd0) ? 2'd2 : i - 2'd1;
  endfunction

  always_comb begin
    unique case (edge_r)
      2'd0: begin e_sel = ent_r.ea; p_sel = ent_r.a; end
      2'd1: begin e_sel = ent_r.eb; p_sel = ent_r.c; end
      default: begin e_sel = ent_r.ec; p_sel = ent_r.b; end
    endcase
    for (int k = 0; k < 3; k++) begin
      f_v[k] = 33'($signed(h_r[k])) - 33'($signed(p_sel[k]));
    end
    u_v = nrm_ph_r ? ent_r.ec : e_sel;
    v_v = nrm_ph_r ? ent_r.ea : f_v;
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    op_neg = 1'b0;
    op_sh = 1'b0;
    term_last = 1'b0;
    unique case (state_r)
      S_CROSS: begin
        term_last = tc_r[0];
        if (!tc_r[0]) begin
          op_a = MW'($signed(u_v[nx3(ci_r)]));
          op_b = MW'($signed(v_v[pv3(ci_r)]));
        end else begin
          op_a = MW'($signed(u_v[pv3(ci_r)]));
          op_b = MW'($signed(v_v[nx3(ci_r)]));
          op_neg = 1'b1;
        end
      end
      S_DEN: begin
        term_last = (tc_r == 3'd2);
        op_a = MW'($signed(cfg_d[tc_r[1:0]]));
        op_b = MW'($signed(nrm_r[tc_r[1:0]][31:0]));
      end
      S_NUM: begin
        term_last = (tc_r == 3'd2);
        op_a = MW'($signed(cfg_o[tc_r[1:0]])) - MW'($signed(ent_r.a[tc_r[1:0]]));
        op_b = MW'($signed(nrm_r[tc_r[1:0]][31:0]));
        op_neg = 1'b1;
      end
      S_PROD: begin
        term_last = tc_r[0];
        op_b = MW'($signed(cfg_d[ci_r]));
        if (!tc_r[0]) begin
          op_a = {1'b0, num_r[SP-1:0]};
        end else begin
          op_a = MW'($signed(num_r[rtnp_pkg::NUM_W-1:SP]));
          op_sh = 1'b1;
        end
      end
      S_DOT: begin
        term_last = (tc_r == 3'd5);
        op_b = MW'($signed(nrm_r[tc_r[2:1]][31:0]));
        if (!tc_r[0]) begin
          op_a = {1'b0, t_r[tc_r[2:1]][SP-1:0]};
        end else begin
          op_a = MW'($signed(t_r[tc_r[2:1]][rtnp_pkg::NRM_W-1:SP]));
          op_sh = 1'b1;
        end
      end
      S_DIST: begin
        term_last = tc_r[0];
        op_a = MW'($signed(cfg_o[{1'b0, tc_r[0]}])) - MW'($signed(h_r[{1'b0, tc_r[0]}]));
        op_b = op_a;
      end
      default: ;
    endcase
  end

  assign term_ext = AW'(prod_r);
  assign term_sh = sh_r ? {term_ext[AW-SP-1:0], {SP{1'b0}}} : term_ext;
  assign base = (tc_r == 3'd0) ? '0 : acc_r;
  assign acc_sum = neg_r ? (base - term_sh) : (base + term_sh);

  always_comb begin
    mag_or = '0;
    for (int k = 0; k < 3; k++) begin
      mag_or = mag_or | (nrm_r[k] ^ {rtnp_pkg::NRM_W{nrm_r[k][rtnp_pkg::NRM_W-1]}});
    end
  end

  assign div_start = (state_r == S_PROD) && ph_r && term_last;

  rtnp_div u_div (
    .clk(clk),
    .rst_n(rst_n),
    .start(div_start),
    .dividend(acc_sum),
    .divisor(den_r),
    .done(div_done),
    .quotient(div_q)
  );

  assign osum = AW'($signed(cfg_o[ci_r])) + div_q;

  always_comb begin
    if (osum[AW-1] && !(&osum[AW-2:31])) begin
      h_sat = 32'h8000_0000;
    end else if (!osum[AW-1] && (|osum[AW-2:31])) begin
      h_sat = 32'h7FFF_FFFF;
    end else begin
      h_sat = osum[31:0];
    end
  end

  assign dist_val = (|acc_sum[AW-1:rtnp_pkg::DIST_W]) ? '1 : acc_sum[rtnp_pkg::DIST_W-1:0];
  assign out_free = !out_valid_r || out_tready;
  assign out_load = (state_r == S_FIN) && ent_r.last && out_free;
  assign pop_ready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_picked_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r <= 1'b0;
      tc_r <= '0;
      ci_r <= '0;
      edge_r <= '0;
      nrm_ph_r <= 1'b0;
      any_hit_r <= 1'b0;
      best_d_r <= '0;
      best_x_r <= '0;
      best_y_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            ent_r <= pop_entry;
            nrm_ph_r <= 1'b1;
            edge_r <= '0;
            ci_r <= '0;
            tc_r <= '0;
            ph_r <= 1'b0;
            state_r <= S_CROSS;
          end
        end
        S_NORM: begin
          if (|mag_or[rtnp_pkg::NRM_W-1:31]) begin
            for (int k = 0; k < 3; k++) begin
              nrm_r[k] <= {nrm_r[k][rtnp_pkg::NRM_W-1], nrm_r[k][rtnp_pkg::NRM_W-1:1]};
            end
          end else begin
            state_r <= S_DEN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            h_r[ci_r] <= h_sat;
            if (ci_r == 2'd2) begin
              ci_r <= '0;
              edge_r <= '0;
              state_r <= S_CROSS;
            end else begin
              ci_r <= ci_r + 2'd1;
              state_r <= S_PROD;
            end
          end
        end
        S_FIN: begin
          if (!ent_r.last) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_picked_r <= any_hit_r;
            out_data_r <= {best_y_r, best_x_r};
            any_hit_r <= 1'b0;
            best_d_r <= '0;
            best_x_r <= '0;
            best_y_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          if (!ph_r) begin
            prod_r <= op_a * op_b;
            sh_r <= op_sh;
            neg_r <= op_neg;
            ph_r <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            acc_r <= acc_sum;
            if (!term_last) begin
              tc_r <= tc_r + 3'd1;
            end else begin
              tc_r <= '0;
              priority case (state_r)
                S_CROSS: begin
                  if (nrm_ph_r) begin
                    nrm_r[ci_r] <= acc_sum[rtnp_pkg::NRM_W-1:0];
                  end else begin
                    t_r[ci_r] <= acc_sum[rtnp_pkg::NRM_W-1:0];
                  end
                  if (ci_r == 2'd2) begin
                    ci_r <= '0;
                    nrm_ph_r <= 1'b0;
                    state_r <= nrm_ph_r ? S_NORM : S_DOT;
                  end else begin
                    ci_r <= ci_r + 2'd1;
                  end
                end
                S_DEN: begin
                  den_r <= acc_sum[rtnp_pkg::DEN_W-1:0];
                  state_r <= (acc_sum[rtnp_pkg::DEN_W-1:0] == '0) ? S_FIN : S_NUM;
                end
                S_NUM: begin
                  num_r <= acc_sum[rtnp_pkg::NUM_W-1:0];
                  ci_r <= '0;
                  state_r <= S_PROD;
                end
                S_PROD: begin
                  state_r <= S_DIV;
                end
                S_DOT: begin
                  if (acc_sum[AW-1]) begin
                    state_r <= S_FIN;
                  end else if (edge_r == 2'd2) begin
                    state_r <= S_DIST;
                  end else begin
                    edge_r <= edge_r + 2'd1;
                    state_r <= S_CROSS;
                  end
                end
                default: begin
                  if (!any_hit_r || dist_val < best_d_r) begin
                    best_d_r <= dist_val;
                    best_x_r <= h_r[0];
                    best_y_r <= h_r[1];
                  end
                  any_hit_r <= 1'b1;
                  state_r <= S_FIN;
                end
              endcase
            end
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/ray_triangle_nearest_pick_unit.sv @@
// Nearest ray/triangle pick over a stream of triangles.
// The cfg channel writes the line origin (indices 0 to 2) and direction
// (indices 3 to 5); indices 6 and 7 are ignored. Write only while idle.
// Each in item is one triangle: nine Q23.8 coordinates in in_tdata and
// in_tlast marking the final triangle of a mesh. Every triangle is checked
// against the line and the hit nearest the origin in xy is kept.
// After the item with in_tlast, one out item carries the pick flag in
// out_tuser and the hit x and y in out_tdata, and the kept hit is cleared.
// An input register and a two-entry queue sit in front of a sequencer with
// one shared 35 by 35 bit multiplier and a one bit per cycle divider.
// Most of the time of a triangle that reaches the inside tests goes into
// the three divisions; a parallel or degenerate one stops before them,
// and one outside an edge takes somewhat less time than a hit. The time
// also varies as the normal is normalized one bit per cycle.
// Items are taken one at a time by the sequencer; the queue holds two more.
// After reset the origin is zero, the direction is +z and no hit is kept.
// A stalled receiver holds the result in the output register; the
// sequencer only waits when a second result is due before it is taken.
`default_nettype none
module ray_triangle_nearest_pick_unit #(
  parameter int QUEUE_DEPTH = rtnp_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [rtnp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic in_tvalid,
  output logic in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  wire logic [287:0] in_tdata,
  input  wire logic in_tlast,
  output logic out_tvalid,
  input  wire logic out_tready,
  // hit_x, hit_y
  output logic [63:0] out_tdata,
  // picked
  output logic out_tuser
);

  rtnp_pkg::vec_t org_r;
  rtnp_pkg::vec_t dir_r;
  logic push_valid;
  logic push_ready;
  rtnp_pkg::entry_t push_entry;
  logic pop_valid;
  logic pop_ready;
  rtnp_pkg::entry_t pop_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r <= '0;
      dir_r <= {32'sd256, 32'sd0, 32'sd0};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rtnp_pkg::REG_ORIGIN_X: org_r[0] <= cfg_data;
        rtnp_pkg::REG_ORIGIN_Y: org_r[1] <= cfg_data;
        rtnp_pkg::REG_ORIGIN_Z: org_r[2] <= cfg_data;
        rtnp_pkg::REG_DIR_X: dir_r[0] <= cfg_data;
        rtnp_pkg::REG_DIR_Y: dir_r[1] <= cfg_data;
        rtnp_pkg::REG_DIR_Z: dir_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  rtnp_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_entry(push_entry)
  );

  rtnp_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_entry(push_entry),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_entry(pop_entry)
  );

  rtnp_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_o(org_r),
    .cfg_d(dir_r),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_entry(pop_entry),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

endmodule
`default_nettype wire
